/* rtl/mpk_pkg.sv */
`default_nettype none

package mpk_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int LEN_W      = 11;
    localparam int TONE_W     = 12;
    localparam int LOCK_W     = 13;

    localparam logic [LEN_W-1:0]  LEN_MAX    = 11'd1200;
    localparam logic [TONE_W-1:0] DAH_FACTOR = 12'd3;

    // key mode codes
    localparam logic [1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [1:0] MODE_IAMBIC   = 2'd1;
    localparam logic [1:0] MODE_SINGLE   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIT_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTH = 2'd2;

    localparam logic [1:0]       KEY_MODE_RST = MODE_IAMBIC;
    localparam logic [LEN_W-1:0] DIT_LEN_RST  = 11'd60;
    localparam logic [LEN_W-1:0] GAP_LEN_RST  = 11'd60;

    typedef struct packed {
        logic [1:0]       key_mode;
        logic [LEN_W-1:0] dit_len;   // already clamped to 1..1200
        logic [LEN_W-1:0] gap_len;   // already clamped to 1..1200
    } cfg_t;

    typedef struct packed {
        logic key_down;
        logic element_start;
        logic element_is_dah;
    } result_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
        begin
            r = LEN_W'(1);
        end
        else if (v > LEN_MAX)
        begin
            r = LEN_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/mpk_cfg_if.sv */
`default_nettype none

interface mpk_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mpk_pkg::CFG_IDX_W-1:0]    index;
    logic [mpk_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/mpk_tick_if.sv */
`default_nettype none

interface mpk_tick_if;
    logic valid;
    logic ready;
    logic dit_pressed;
    logic dah_pressed;

    modport source (output valid, output dit_pressed, output dah_pressed, input ready);
    modport sink   (input valid, input dit_pressed, input dah_pressed, output ready);
endinterface

`default_nettype wire

/* rtl/mpk_result_if.sv */
`default_nettype none

interface mpk_result_if;
    logic valid;
    logic ready;
    logic key_down;
    logic element_start;
    logic element_is_dah;

    modport source (output valid, output key_down, output element_start,
                    output element_is_dah, input ready);
    modport sink   (input valid, input key_down, input element_start,
                    input element_is_dah, output ready);
endinterface

`default_nettype wire

/* rtl/mpk_cfg_regs.sv */
`default_nettype none

module mpk_cfg_regs (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mpk_cfg_if.sink         cfg,
    output mpk_pkg::cfg_t   cfg_state
);

    logic [1:0]                    key_mode_reg;
    logic [mpk_pkg::LEN_W-1:0]     dit_len_reg;
    logic [mpk_pkg::LEN_W-1:0]     gap_len_reg;
    logic                          wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    // lengths are clamped at write time so the datapath sees 1..1200 only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg <= mpk_pkg::KEY_MODE_RST;
            dit_len_reg  <= mpk_pkg::DIT_LEN_RST;
            gap_len_reg  <= mpk_pkg::GAP_LEN_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg.index)
                mpk_pkg::REG_KEY_MODE:   key_mode_reg <= cfg.data[1:0];
                mpk_pkg::REG_DIT_LENGTH: dit_len_reg  <= mpk_pkg::clamp_len(cfg.data);
                mpk_pkg::REG_GAP_LENGTH: gap_len_reg  <= mpk_pkg::clamp_len(cfg.data);
                default:                 ;
            endcase
        end
    end

    assign cfg_state.key_mode = key_mode_reg;
    assign cfg_state.dit_len  = dit_len_reg;
    assign cfg_state.gap_len  = gap_len_reg;

endmodule

`default_nettype wire

/* rtl/mpk_core.sv */
`default_nettype none

module mpk_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mpk_pkg::cfg_t      cfg_state,
    input  wire logic               accept,
    input  wire logic               dit,
    input  wire logic               dah,
    output mpk_pkg::result_t        result
);

    logic [mpk_pkg::LOCK_W-1:0] lockout_reg, lockout_next;
    logic [mpk_pkg::TONE_W-1:0] tone_reg, tone_next;
    logic                       last_dit_reg, last_dit_next;

    logic                       want;
    logic                       want_dah;
    logic                       start;
    logic [mpk_pkg::TONE_W-1:0] dit_len_w;
    logic [mpk_pkg::TONE_W-1:0] elem_len;

    always_comb
    begin
        want     = 1'b0;
        want_dah = 1'b0;
        unique case (cfg_state.key_mode)
            mpk_pkg::MODE_IAMBIC:
            begin
                want = dit || dah;
                // squeeze plays the opposite of the last element
                want_dah = (dit && dah) ? last_dit_reg : !dit;
            end
            mpk_pkg::MODE_SINGLE:
            begin
                want     = dit || dah;
                want_dah = !dit;
            end
            default:
            begin
                want     = 1'b0;
                want_dah = 1'b0;
            end
        endcase
    end

    assign dit_len_w = mpk_pkg::TONE_W'(cfg_state.dit_len);
    assign elem_len  = want_dah ? dit_len_w * mpk_pkg::DAH_FACTOR : dit_len_w;
    assign start     = want && (lockout_reg == '0);

    always_comb
    begin
        lockout_next  = lockout_reg;
        tone_next     = tone_reg;
        last_dit_next = last_dit_reg;
        if (start)
        begin
            lockout_next  = mpk_pkg::LOCK_W'(cfg_state.gap_len) + mpk_pkg::LOCK_W'(elem_len);
            tone_next     = elem_len - 1'b1;
            last_dit_next = !want_dah;
        end
        else
        begin
            if (lockout_reg != '0)
            begin
                lockout_next = lockout_reg - 1'b1;
            end
            if (tone_reg != '0)
            begin
                tone_next = tone_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg  <= '0;
            tone_reg     <= '0;
            last_dit_reg <= 1'b0;
        end
        else if (accept)
        begin
            lockout_reg  <= lockout_next;
            tone_reg     <= tone_next;
            last_dit_reg <= last_dit_next;
        end
    end

    assign result.key_down = (cfg_state.key_mode == mpk_pkg::MODE_STRAIGHT) ?
                             (dit || dah) : (start || (tone_reg != '0));
    assign result.element_start  = start;
    assign result.element_is_dah = start && want_dah;

endmodule

`default_nettype wire

/* rtl/mpk_out_reg.sv */
`default_nettype none

module mpk_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire mpk_pkg::result_t  result,
    output logic                   can_load,
    mpk_result_if.source           out
);

    logic             valid_reg, valid_next;
    mpk_pkg::result_t data_reg;

    // a new tick can enter while the held result leaves in the same cycle
    assign can_load   = !valid_reg || out.ready;
    assign valid_next = load || (valid_reg && !out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out.valid          = valid_reg;
    assign out.key_down       = data_reg.key_down;
    assign out.element_start  = data_reg.element_start;
    assign out.element_is_dah = data_reg.element_is_dah;

endmodule

`default_nettype wire

/* rtl/morse_paddle_keyer_unit.sv */
// The result of a transferred tick is registered in the output register.
// Throughput: one tick per cycle; the output register takes a new result while
// the held one leaves, so the input stalls only while the output side stalls.
// Reset (rst_n, async, active low): timers and history cleared, key mode iambic,
// dit and gap length 60 ticks, output empty.
`default_nettype none

module morse_paddle_keyer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mpk_cfg_if.sink         cfg,
    mpk_tick_if.sink        tick,
    mpk_result_if.source    result
);

    mpk_pkg::cfg_t    cfg_state;
    mpk_pkg::result_t core_result;
    logic             can_load;
    logic             tick_xfer;

    assign tick.ready = can_load;
    assign tick_xfer  = tick.valid && tick.ready;

    mpk_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    mpk_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_state (cfg_state),
        .accept    (tick_xfer),
        .dit       (tick.dit_pressed),
        .dah       (tick.dah_pressed),
        .result    (core_result)
    );

    mpk_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (tick_xfer),
        .result   (core_result),
        .can_load (can_load),
        .out      (result)
    );

    a_dah_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.element_is_dah |-> result.element_start)
        else $error("dah flag without element start");

    a_start_keys: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.element_start |-> result.key_down)
        else $error("element start without key down");

    a_xfer_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        tick_xfer |=> result.valid)
        else $error("accepted tick produced no result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> result.valid && !result.ready)
        else $error("input stalled with free output register");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_TICKS = 420;

    // index with no register behind it, and the unused key mode code
    localparam logic [mpk_pkg::CFG_IDX_W-1:0] REG_NONE      = 2'd3;
    localparam logic [1:0]                    MODE_RESERVED = 2'd3;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [mpk_pkg::CFG_IDX_W-1:0]  idx;
        logic [mpk_pkg::CFG_DATA_W-1:0] data;
        logic                           dit;
        logic                           dah;
        logic                           fixed;
        mpk_pkg::result_t               want;
    } dir_row_t;

    localparam mpk_pkg::result_t R_IDLE =
        '{key_down: 1'b0, element_start: 1'b0, element_is_dah: 1'b0};
    localparam mpk_pkg::result_t R_KEY  =
        '{key_down: 1'b1, element_start: 1'b0, element_is_dah: 1'b0};
    localparam mpk_pkg::result_t R_DIT  =
        '{key_down: 1'b1, element_start: 1'b1, element_is_dah: 1'b0};

    localparam int N_DIR = 35;

    // fixed rows carry a typed-in result, the others go through the predictor
    dir_row_t dir_rows [N_DIR] = '{
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b0, 1'b1, R_IDLE},
        '{ROW_CFG,  mpk_pkg::REG_KEY_MODE,   11'd0,   1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b0, 1'b1, R_KEY},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b1, 1'b1, R_KEY},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b1, 1'b1, R_KEY},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b0, 1'b1, R_IDLE},
        '{ROW_CFG,  mpk_pkg::REG_KEY_MODE,   11'd3,   1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b1, 1'b1, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b0, 1'b1, R_IDLE},
        '{ROW_CFG,  REG_NONE,                11'h7FF, 1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_CFG,  mpk_pkg::REG_DIT_LENGTH, 11'd0,   1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_CFG,  mpk_pkg::REG_GAP_LENGTH, 11'd0,   1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_CFG,  mpk_pkg::REG_KEY_MODE,   11'h7FD, 1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b1, 1'b1, R_DIT},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b0, 1'b0, R_IDLE},
        '{ROW_CFG,  mpk_pkg::REG_KEY_MODE,   11'd2,   1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b1, 1'b1, 1'b0, R_IDLE},
        '{ROW_CFG,  mpk_pkg::REG_DIT_LENGTH, 11'd3,   1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b1, 1'b0, R_IDLE},
        '{ROW_CFG,  mpk_pkg::REG_KEY_MODE,   11'd3,   1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b1, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b0, 1'b0, R_IDLE},
        '{ROW_TICK, REG_NONE,                11'd0,   1'b0, 1'b0, 1'b0, R_IDLE}
    };

    logic clk;
    logic rst_n;

    mpk_cfg_if    cfg_bus ();
    mpk_tick_if   tick_bus ();
    mpk_result_if res_bus ();

    morse_paddle_keyer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .tick   (tick_bus),
        .result (res_bus)
    );

    // keyer state as the block should hold it
    logic [1:0]                 key_mode;
    logic [mpk_pkg::LEN_W-1:0]  dit_cfg;
    logic [mpk_pkg::LEN_W-1:0]  gap_cfg;
    logic [mpk_pkg::LOCK_W-1:0] lock_left;
    logic [mpk_pkg::TONE_W-1:0] tone_left;
    logic                       last_dit;

    mpk_pkg::result_t pending_keying [$];

    int cycle_count;
    int errors;
    int ticks_sent;
    int results_seen;
    int dits_started;
    int dahs_started;
    int reg_writes;
    int burst_left;
    int hold_left;
    logic hold_dit;
    logic hold_dah;
    int stall_left;
    int stall_style;
    int stall_phase;
    mpk_pkg::result_t got;
    mpk_pkg::result_t want;

    always #5 clk = ~clk;

    function automatic logic [mpk_pkg::LEN_W-1:0] eff_len(
        input logic [mpk_pkg::LEN_W-1:0] v);
        logic [mpk_pkg::LEN_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = mpk_pkg::LEN_W'(1);
        end
        else if (v > mpk_pkg::LEN_MAX)
        begin
            r = mpk_pkg::LEN_MAX;
        end
        return r;
    endfunction

    function automatic mpk_pkg::result_t compute_keying(input logic dit, input logic dah);
        logic [mpk_pkg::TONE_W-1:0] dl;
        logic [mpk_pkg::TONE_W-1:0] len;
        logic                       want_el;
        logic                       want_dah;
        logic                       start;
        mpk_pkg::result_t           r;
        dl       = mpk_pkg::TONE_W'(eff_len(dit_cfg));
        want_el  = 1'b0;
        want_dah = 1'b0;
        start    = 1'b0;
        if (key_mode == mpk_pkg::MODE_IAMBIC)
        begin
            want_el  = dit | dah;
            // squeeze alternates against the previous element
            want_dah = (dit && dah) ? last_dit : dah && !dit;
        end
        else if (key_mode == mpk_pkg::MODE_SINGLE)
        begin
            want_el  = dit | dah;
            want_dah = dah && !dit;
        end
        if (want_el && lock_left == '0)
        begin
            len       = want_dah ? dl * mpk_pkg::DAH_FACTOR : dl;
            start     = 1'b1;
            tone_left = len;
            lock_left = mpk_pkg::LOCK_W'(eff_len(gap_cfg)) + mpk_pkg::LOCK_W'(len);
            last_dit  = !want_dah;
        end
        else if (lock_left != '0)
        begin
            lock_left = lock_left - 1'b1;
        end
        r.key_down       = (key_mode == mpk_pkg::MODE_STRAIGHT) ? (dit | dah)
                                                                 : (tone_left != '0);
        r.element_start  = start;
        r.element_is_dah = start & want_dah;
        if (tone_left != '0)
        begin
            tone_left = tone_left - 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30)
        begin
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_tick(input logic dit, input logic dah, input logic fixed,
                             input mpk_pkg::result_t fixed_res);
        mpk_pkg::result_t r;
        if (burst_left == 0)
        begin
            tick_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
        end
        tick_bus.valid       <= 1'b1;
        tick_bus.dit_pressed <= dit;
        tick_bus.dah_pressed <= dah;
        do @(posedge clk); while (!tick_bus.ready);
        r = compute_keying(dit, dah);
        pending_keying.push_back(fixed ? fixed_res : r);
        ticks_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // sender holds off until every result is back
    task automatic wait_keying_drained();
        tick_bus.valid <= 1'b0;
        while (pending_keying.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_keyer_reg(input logic [mpk_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [mpk_pkg::CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            mpk_pkg::REG_KEY_MODE:   key_mode = val[1:0];
            mpk_pkg::REG_DIT_LENGTH: dit_cfg  = val;
            mpk_pkg::REG_GAP_LENGTH: gap_cfg  = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    // paddles held for runs near the element timing, with some one-tick noise
    task automatic next_paddles(output logic dit, output logic dah);
        int unsigned cap;
        int unsigned pat;
        if (hold_left == 0)
        begin
            cap       = 4 * eff_len(dit_cfg) + eff_len(gap_cfg);
            pat       = $urandom_range(0, 3);
            hold_dit  = pat[0];
            hold_dah  = pat[1];
            hold_left = $urandom_range(1, cap);
        end
        hold_left--;
        dit = hold_dit;
        dah = hold_dah;
        if ($urandom_range(0, 11) == 0)
        begin
            pat = $urandom_range(0, 3);
            dit = pat[0];
            dah = pat[1];
        end
    endtask

    task automatic run_phase(input logic [1:0] mode,
                             input logic [mpk_pkg::LEN_W-1:0] dlen,
                             input logic [mpk_pkg::LEN_W-1:0] glen, input int n);
        logic d;
        logic a;
        wait_keying_drained();
        write_keyer_reg(mpk_pkg::REG_KEY_MODE, {9'($urandom_range(0, 511)), mode});
        write_keyer_reg(mpk_pkg::REG_DIT_LENGTH, dlen);
        write_keyer_reg(mpk_pkg::REG_GAP_LENGTH, glen);
        hold_left = 0;
        for (int i = 0; i < n; i++)
        begin
            next_paddles(d, a);
            send_tick(d, a, 1'b0, R_IDLE);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got = '{res_bus.key_down, res_bus.element_start, res_bus.element_is_dah};
            results_seen++;
            if (got.element_start)
            begin
                if (got.element_is_dah)
                begin
                    dahs_started++;
                end
                else
                begin
                    dits_started++;
                end
            end
            if (pending_keying.size() == 0)
            begin
                report_mismatch("result transfer with nothing pending");
            end
            else
            begin
                want = pending_keying.pop_front();
                if (got.key_down !== want.key_down)
                begin
                    report_mismatch($sformatf("key_down %b, want %b",
                                              got.key_down, want.key_down));
                end
                if (got.element_start !== want.element_start)
                begin
                    report_mismatch($sformatf("element_start %b, want %b",
                                              got.element_start, want.element_start));
                end
                if (got.element_is_dah !== want.element_is_dah)
                begin
                    report_mismatch($sformatf("element_is_dah %b, want %b",
                                              got.element_is_dah, want.element_is_dah));
                end
            end
        end
    end

    // receiver stalls: switches between always ready, random and a fixed pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(50, 300);
        end
        stall_left--;
        stall_phase++;
        case (stall_style)
            0: res_bus.ready <= 1'b1;
            1: res_bus.ready <= 1'($urandom_range(0, 1));
            2: res_bus.ready <= ($urandom_range(0, 4) != 0);
            default: res_bus.ready <= (stall_phase % 4 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int rand_done;
        int phase_no;
        int unsigned pick;
        logic [1:0] mode;
        int n;

        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = '0;
        cfg_bus.data         = '0;
        tick_bus.valid       = 1'b0;
        tick_bus.dit_pressed = 1'b0;
        tick_bus.dah_pressed = 1'b0;
        res_bus.ready        = 1'b0;
        cycle_count  = 0;
        errors       = 0;
        ticks_sent   = 0;
        results_seen = 0;
        dits_started = 0;
        dahs_started = 0;
        reg_writes   = 0;
        burst_left   = 0;
        hold_left    = 0;
        hold_dit     = 1'b0;
        hold_dah     = 1'b0;
        stall_left   = 0;
        stall_style  = 0;
        stall_phase  = 0;
        key_mode  = mpk_pkg::KEY_MODE_RST;
        dit_cfg   = mpk_pkg::DIT_LEN_RST;
        gap_cfg   = mpk_pkg::GAP_LEN_RST;
        lock_left = '0;
        tone_left = '0;
        last_dit  = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_keying_drained();
                write_keyer_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                send_tick(dir_rows[i].dit, dir_rows[i].dah, dir_rows[i].fixed,
                          dir_rows[i].want);
            end
        end

        // random phases with short elements; first few walk through every mode
        rand_done = 0;
        phase_no  = 0;
        while (rand_done < RANDOM_TICKS)
        begin
            if (phase_no < 4)
            begin
                case (phase_no)
                    0: mode = mpk_pkg::MODE_IAMBIC;
                    1: mode = mpk_pkg::MODE_SINGLE;
                    2: mode = mpk_pkg::MODE_STRAIGHT;
                    default: mode = MODE_RESERVED;
                endcase
            end
            else
            begin
                pick = $urandom_range(0, 9);
                mode = (pick == 0) ? mpk_pkg::MODE_STRAIGHT :
                       (pick < 5)  ? mpk_pkg::MODE_IAMBIC :
                       (pick < 9)  ? mpk_pkg::MODE_SINGLE : MODE_RESERVED;
            end
            n = $urandom_range(40, 120);
            run_phase(mode, mpk_pkg::LEN_W'($urandom_range(0, 10)),
                      mpk_pkg::LEN_W'($urandom_range(0, 10)), n);
            rand_done += n;
            phase_no++;
        end

        // longest lengths: over-range values clamp to the maximum
        run_phase(mpk_pkg::MODE_IAMBIC, 11'h7FF, 11'd0, 50);
        run_phase(mpk_pkg::MODE_SINGLE, 11'd0, mpk_pkg::LEN_MAX, 50);
        run_phase(mpk_pkg::MODE_IAMBIC, mpk_pkg::LEN_MAX, 11'd1201, 40);

        wait_keying_drained();
        repeat (10) @(negedge clk);
        if (pending_keying.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_keying.size()));
        end

        $display("Run: %0d ticks, %0d results checked, %0d register writes, %0d cycles",
                 ticks_sent, results_seen, reg_writes, cycle_count);
        $display("Elements started: %0d dits, %0d dahs; %0d mismatches",
                 dits_started, dahs_started, errors);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
